// ===== rtl/epoch_ms_to_civil_datetime_core_assert.svh =====
// Assertion macros shared by the converter RTL.
// Each use stands on a line of its own and takes no trailing semicolon.
`ifndef EPOCH_MS_TO_CIVIL_DATETIME_CORE_ASSERT_SVH
`define EPOCH_MS_TO_CIVIL_DATETIME_CORE_ASSERT_SVH

// Concurrent check on an explicit clock and active-low reset.
`define ECD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the module's own clk_i / rst_ni.
`define ECD_ASSERT(lbl, prop, msg) \
  `ECD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/ecd_pkg.sv =====
`timescale 1ns / 1ps
package ecd_pkg;

  // Port field widths
  localparam int EpochW  = 48;
  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DomW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int MsecW   = 10;

  // Pipeline depth
  localparam int NumStages = 14;
  localparam int StgLast   = NumStages - 1;

  // Day split: ms = days * 86400000 + ms_of_day, 86400000 = 84375 << 10
  localparam int MsLoW  = 10;
  localparam int XloW   = 15;
  localparam int XhiW   = EpochW - MsLoW - XloW;
  localparam int RemW   = 17;
  localparam int Q1W    = 7;
  localparam int Q2W    = 15;
  localparam int NumW   = RemW + XloW;
  localparam int DaysW  = Q1W + Q2W;
  localparam int MsodW  = RemW + MsLoW;
  localparam int RecipHiW = 7;
  localparam int RecipLoW = 16;
  localparam logic [RemW-1:0]     DayMsOdd = RemW'(84375);
  localparam logic [RecipHiW-1:0] RecipHi  = RecipHiW'(99);
  localparam logic [RecipLoW-1:0] RecipLo  = RecipLoW'(50903);

  // Civil date
  localparam int EraW   = 5;
  localparam int DoeW   = 18;
  localparam int YoeW   = 9;
  localparam int DoyW   = 9;
  localparam int MpW    = 4;
  localparam logic [DaysW-1:0] DayShift    = DaysW'(719468);
  localparam logic [DoeW-1:0]  EraDays     = DoeW'(146097);
  localparam logic [DoeW-1:0]  EraLastDay  = DoeW'(146096);
  localparam logic [DoeW-1:0]  CentDays    = DoeW'(36524);
  localparam logic [DoeW-1:0]  DaysPerYear = DoeW'(365);
  localparam logic [YearW-1:0] YearsPerEra = YearW'(400);
  localparam logic [EraW-1:0]  RecipEra    = EraW'(28);
  localparam logic [15:0]      RecipQuad   = 16'(45965);
  localparam logic [17:0]      RecipYear   = 18'(183860);
  localparam logic [5:0]       RecipCent   = 6'(41);
  localparam logic [9:0]       RecipMon    = 10'(857);

  // Time of day
  localparam int SodW    = 17;
  localparam int MinRemW = 12;
  localparam logic [24:0]        RecipSec   = 25'(17179870);
  localparam logic [MsecW-1:0]   MsPerSec   = MsecW'(1000);
  localparam logic [12:0]        RecipHour  = 13'(4661);
  localparam logic [MinRemW-1:0] SecPerHour = MinRemW'(3600);
  localparam logic [10:0]        RecipMin   = 11'(1093);
  localparam logic [SecW-1:0]    SecPerMin  = SecW'(60);

  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } ecd_ctrl_t;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
    logic [MsecW-1:0] msec;
  } ecd_time_t;

  // First day of the March-based month mp, counted from March 1
  function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
    logic [DoyW-1:0] r;
    case (mp)
      4'd0:    r = DoyW'(0);
      4'd1:    r = DoyW'(31);
      4'd2:    r = DoyW'(61);
      4'd3:    r = DoyW'(92);
      4'd4:    r = DoyW'(122);
      4'd5:    r = DoyW'(153);
      4'd6:    r = DoyW'(184);
      4'd7:    r = DoyW'(214);
      4'd8:    r = DoyW'(245);
      4'd9:    r = DoyW'(275);
      4'd10:   r = DoyW'(306);
      4'd11:   r = DoyW'(337);
      default: r = DoyW'(0);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ecd_if.sv =====
`timescale 1ns / 1ps
interface ecd_req_if;
  logic                        valid;
  logic                        ready;
  logic [ecd_pkg::EpochW-1:0]  epoch_ms;
  modport source (output valid, output epoch_ms, input ready);
  modport sink   (input valid, input epoch_ms, output ready);
endinterface

interface ecd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ecd_pkg::YearW-1:0]   year;
  logic [ecd_pkg::MonthW-1:0]  month;
  logic [ecd_pkg::DomW-1:0]    day_of_month;
  logic [ecd_pkg::HourW-1:0]   hour;
  logic [ecd_pkg::MinW-1:0]    minute;
  logic [ecd_pkg::SecW-1:0]    second;
  logic [ecd_pkg::MsecW-1:0]   millisecond;
  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output millisecond,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input millisecond,
                  output ready);
endinterface

// ===== rtl/epoch_ms_to_civil_datetime_core.sv =====
`timescale 1ns / 1ps
// 14 register stages (0-13), the first loaded at the accepting edge. Accepts one
// request per cycle while the output drains or a bubble sits in the pipeline.
// Backpressure holds the full pipeline; any bubble keeps the input ready.
// Reset (rst_ni, async, active low) clears only the stage valid bits; no state.
module epoch_ms_to_civil_datetime_core (
  input logic       clk_i,
  input logic       rst_ni,
  ecd_req_if.sink   req_i,
  ecd_rsp_if.source rsp_o
);
  import ecd_pkg::*;

  ecd_ctrl_t         ctrl;
  logic              in_ready;
  logic              out_valid;
  logic [DaysW-1:0]  days;
  logic [MsodW-1:0]  ms_of_day;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DomW-1:0]   dom;
  ecd_time_t         tod;

  // Valid bits and per-stage load enables; a stage loads when the output
  // drains or a bubble sits at or after it, so bubbles collapse under stall.
  ecd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  // Stages 0-5: split the count into whole days and ms of day. The divide by
  // 86400000 runs as two reciprocal-multiply chunks, each with a one-step fix.
  ecd_day_split u_day (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .epoch_ms_i  (req_i.epoch_ms),
    .days_o      (days),
    .ms_of_day_o (ms_of_day)
  );

  // Stages 6-13: era based civil-from-days conversion; March starts the
  // internal year, so Jan and Feb carry into the next calendar year.
  ecd_civil_date u_date (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .days_i  (days),
    .year_o  (year),
    .month_o (month),
    .dom_o   (dom)
  );

  // Stages 6-13 in parallel: hour, minute, second, millisecond from the
  // ms of day, then delay to line up with the date path.
  ecd_time_split u_time (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .msod_i (ms_of_day),
    .tod_o  (tod)
  );

  assign req_i.ready        = in_ready;
  assign rsp_o.valid        = out_valid;
  assign rsp_o.year         = year;
  assign rsp_o.month        = month;
  assign rsp_o.day_of_month = dom;
  assign rsp_o.hour         = tod.hour;
  assign rsp_o.minute       = tod.minute;
  assign rsp_o.second       = tod.second;
  assign rsp_o.millisecond  = tod.msec;

endmodule

// ===== rtl/ecd_pipe_ctrl.sv =====
`timescale 1ns / 1ps
`include "epoch_ms_to_civil_datetime_core_assert.svh"
module ecd_pipe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ecd_pkg::ecd_ctrl_t ctrl_o
);
  import ecd_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d, en, prev;
  logic                 in_fire, out_fire;

  // A stage may load when the output drains or any bubble sits at or after it
  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      en[k] = out_ready_i || (|((~vld_q) >> k));
    end
  end

  assign prev  = {vld_q[NumStages-2:0], in_valid_i};
  assign vld_d = (en & prev) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[StgLast];
  assign ctrl_o.en   = en;
  assign ctrl_o.vld  = vld_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = vld_q[StgLast] && out_ready_i;

  `ECD_ASSERT(a_ctrl_conserve, rst_ni |=> ($countones(vld_q) == $past($countones(vld_q)) + $past(in_fire) - $past(out_fire)), "request count in pipeline broken")
  `ECD_ASSERT(a_ctrl_bubble_ready, (~&vld_q) |-> in_ready_o, "bubble present but input stalled")

endmodule

// ===== rtl/ecd_day_split.sv =====
`timescale 1ns / 1ps
module ecd_day_split (
  input  logic                       clk_i,
  input  ecd_pkg::ecd_ctrl_t         ctrl_i,
  input  logic [ecd_pkg::EpochW-1:0] epoch_ms_i,
  output logic [ecd_pkg::DaysW-1:0]  days_o,
  output logic [ecd_pkg::MsodW-1:0]  ms_of_day_o
);
  import ecd_pkg::*;

  localparam int P1W = XhiW + RecipHiW;
  localparam int P2W = NumW + RecipLoW;

  // Stage 0: estimate of the high-chunk quotient
  logic [XhiW-1:0]  x_hi;
  logic [P1W-1:0]   q1_prod;
  logic [Q1W-1:0]   s0_q1e_q;
  logic [XhiW-1:0]  s0_xhi_q;
  logic [XloW-1:0]  s0_xlo_q;
  logic [MsLoW-1:0] s0_lo_q;

  assign x_hi    = epoch_ms_i[EpochW-1 -: XhiW];
  assign q1_prod = P1W'(x_hi) * P1W'(RecipHi);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      s0_q1e_q <= q1_prod[P1W-1 -: Q1W];
      s0_xhi_q <= x_hi;
      s0_xlo_q <= epoch_ms_i[MsLoW +: XloW];
      s0_lo_q  <= epoch_ms_i[MsLoW-1:0];
    end
  end

  // Stage 1: partial remainder of the high chunk
  logic [XhiW-1:0]  p1, d1;
  logic [Q1W-1:0]   s1_q1e_q;
  logic [RemW:0]    s1_r1e_q;
  logic [XloW-1:0]  s1_xlo_q;
  logic [MsLoW-1:0] s1_lo_q;

  assign p1 = XhiW'(s0_q1e_q) * XhiW'(DayMsOdd);
  assign d1 = s0_xhi_q - p1;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      s1_q1e_q <= s0_q1e_q;
      s1_r1e_q <= d1[RemW:0];
      s1_xlo_q <= s0_xlo_q;
      s1_lo_q  <= s0_lo_q;
    end
  end

  // Stage 2: fix the high quotient, bring down the low chunk
  logic             fix1;
  logic [RemW:0]    r1_fix;
  logic [Q1W-1:0]   s2_q1_q;
  logic [NumW-1:0]  s2_num_q;
  logic [MsLoW-1:0] s2_lo_q;

  assign fix1   = s1_r1e_q >= {1'b0, DayMsOdd};
  assign r1_fix = fix1 ? s1_r1e_q - {1'b0, DayMsOdd} : s1_r1e_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      s2_q1_q  <= s1_q1e_q + Q1W'(fix1);
      s2_num_q <= {r1_fix[RemW-1:0], s1_xlo_q};
      s2_lo_q  <= s1_lo_q;
    end
  end

  // Stage 3: estimate of the low-chunk quotient
  logic [P2W-1:0]   q2_prod;
  logic [Q1W-1:0]   s3_q1_q;
  logic [NumW-1:0]  s3_num_q;
  logic [Q2W-1:0]   s3_q2e_q;
  logic [MsLoW-1:0] s3_lo_q;

  assign q2_prod = P2W'(s2_num_q) * P2W'(RecipLo);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[3]) begin
      s3_q1_q  <= s2_q1_q;
      s3_num_q <= s2_num_q;
      s3_q2e_q <= q2_prod[NumW +: Q2W];
      s3_lo_q  <= s2_lo_q;
    end
  end

  // Stage 4: partial remainder of the low chunk
  logic [NumW-1:0]  p2, d2;
  logic [Q1W-1:0]   s4_q1_q;
  logic [Q2W-1:0]   s4_q2e_q;
  logic [RemW:0]    s4_r2e_q;
  logic [MsLoW-1:0] s4_lo_q;

  assign p2 = NumW'(s3_q2e_q) * NumW'(DayMsOdd);
  assign d2 = s3_num_q - p2;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[4]) begin
      s4_q1_q  <= s3_q1_q;
      s4_q2e_q <= s3_q2e_q;
      s4_r2e_q <= d2[RemW:0];
      s4_lo_q  <= s3_lo_q;
    end
  end

  // Stage 5: fix the low quotient, reassemble day count and ms of day
  logic          fix2;
  logic [RemW:0] r2_fix;
  logic [DaysW-1:0] days_q;
  logic [MsodW-1:0] msod_q;

  assign fix2   = s4_r2e_q >= {1'b0, DayMsOdd};
  assign r2_fix = fix2 ? s4_r2e_q - {1'b0, DayMsOdd} : s4_r2e_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[5]) begin
      days_q <= {s4_q1_q, s4_q2e_q + Q2W'(fix2)};
      msod_q <= {r2_fix[RemW-1:0], s4_lo_q};
    end
  end

  assign days_o      = days_q;
  assign ms_of_day_o = msod_q;

endmodule

// ===== rtl/ecd_civil_date.sv =====
`timescale 1ns / 1ps
`include "epoch_ms_to_civil_datetime_core_assert.svh"
module ecd_civil_date (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ecd_pkg::ecd_ctrl_t         ctrl_i,
  input  logic [ecd_pkg::DaysW-1:0]  days_i,
  output logic [ecd_pkg::YearW-1:0]  year_o,
  output logic [ecd_pkg::MonthW-1:0] month_o,
  output logic [ecd_pkg::DomW-1:0]   dom_o
);
  import ecd_pkg::*;

  localparam int PeW  = DaysW + EraW;
  localparam int PqW  = 32;
  localparam int PyW  = 36;
  localparam int PcW  = 14;
  localparam int TW   = 11;
  localparam int PmW  = 21;

  // Stage 6: shift to the March-based era origin, estimate the era
  logic [DaysW-1:0] z;
  logic [PeW-1:0]   era_prod;
  logic [DaysW-1:0] s6_z_q;
  logic [EraW-1:0]  s6_era_q;

  assign z        = days_i + DayShift;
  assign era_prod = PeW'(z) * PeW'(RecipEra);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[6]) begin
      s6_z_q   <= z;
      s6_era_q <= era_prod[DaysW +: EraW];
    end
  end

  // Stage 7: day of era, possibly one era too many
  logic [DaysW-1:0] pe, de;
  logic [EraW-1:0]  s7_era_q;
  logic [DoeW:0]    s7_doe_q;

  assign pe = DaysW'(s6_era_q) * DaysW'(EraDays);
  assign de = s6_z_q - pe;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[7]) begin
      s7_era_q <= s6_era_q;
      s7_doe_q <= de[DoeW:0];
    end
  end

  // Stage 8: fix era and day of era
  logic            fixe;
  logic [DoeW:0]   doe_fix;
  logic [EraW-1:0] s8_era_q;
  logic [DoeW-1:0] s8_doe_q;

  assign fixe    = s7_doe_q >= {1'b0, EraDays};
  assign doe_fix = fixe ? s7_doe_q - {1'b0, EraDays} : s7_doe_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[8]) begin
      s8_era_q <= s7_era_q + EraW'(fixe);
      s8_doe_q <= doe_fix[DoeW-1:0];
    end
  end

  // Stage 9: drop leap days to get a 365-day numerator
  logic [PqW-1:0]  quad_prod;
  logic [6:0]      n_quad;
  logic [2:0]      n_cent;
  logic            n_era;
  logic [DoeW-1:0] num;
  logic [EraW-1:0] s9_era_q;
  logic [DoeW-1:0] s9_doe_q;
  logic [DoeW-1:0] s9_num_q;

  assign quad_prod = PqW'(s8_doe_q[DoeW-1:2]) * PqW'(RecipQuad);
  assign n_quad    = quad_prod[24 +: 7];
  assign n_cent    = 3'(s8_doe_q >= CentDays) + 3'(s8_doe_q >= DoeW'(CentDays * 2))
                   + 3'(s8_doe_q >= DoeW'(CentDays * 3)) + 3'(s8_doe_q >= DoeW'(CentDays * 4));
  assign n_era     = s8_doe_q == EraLastDay;
  assign num       = s8_doe_q - DoeW'(n_quad) + DoeW'(n_cent) - DoeW'(n_era);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[9]) begin
      s9_era_q <= s8_era_q;
      s9_doe_q <= s8_doe_q;
      s9_num_q <= num;
    end
  end

  // Stage 10: year of era
  logic [PyW-1:0]  yoe_prod;
  logic [EraW-1:0] s10_era_q;
  logic [DoeW-1:0] s10_doe_q;
  logic [YoeW-1:0] s10_yoe_q;

  assign yoe_prod = PyW'(s9_num_q) * PyW'(RecipYear);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[10]) begin
      s10_era_q <= s9_era_q;
      s10_doe_q <= s9_doe_q;
      s10_yoe_q <= yoe_prod[26 +: YoeW];
    end
  end

  // Stage 11: March-based year and day of year
  logic [YearW-1:0] y;
  logic [DoeW-1:0]  yoe_days, ydays, doy_full;
  logic [PcW-1:0]   cent_prod;
  logic [YearW-1:0] s11_y_q;
  logic [DoyW-1:0]  s11_doy_q;

  assign y         = YearW'(s10_era_q) * YearsPerEra + YearW'(s10_yoe_q);
  assign yoe_days  = DoeW'(s10_yoe_q) * DaysPerYear;
  assign cent_prod = PcW'(s10_yoe_q) * PcW'(RecipCent);
  assign ydays     = yoe_days + DoeW'(s10_yoe_q[YoeW-1:2]) - DoeW'(cent_prod[PcW-1 -: 2]);
  assign doy_full  = s10_doe_q - ydays;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[11]) begin
      s11_y_q   <= y;
      s11_doy_q <= doy_full[DoyW-1:0];
    end
  end

  // Stage 12: March-based month index
  logic [TW-1:0]    t;
  logic [PmW-1:0]   mon_prod;
  logic [YearW-1:0] s12_y_q;
  logic [DoyW-1:0]  s12_doy_q;
  logic [MpW-1:0]   s12_mp_q;

  assign t        = {s11_doy_q, 2'b00} + TW'(s11_doy_q) + TW'(2);
  assign mon_prod = PmW'(t) * PmW'(RecipMon);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[12]) begin
      s12_y_q   <= s11_y_q;
      s12_doy_q <= s11_doy_q;
      s12_mp_q  <= mon_prod[17 +: MpW];
    end
  end

  // Stage 13: day of month, January-based month, year carry for Jan / Feb
  logic [DoyW-1:0]   dom_full;
  logic [MonthW-1:0] m;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DomW-1:0]   dom_q;

  assign dom_full = s12_doy_q - month_start(s12_mp_q) + DoyW'(1);
  assign m        = (s12_mp_q < MpW'(10)) ? s12_mp_q + MpW'(3) : s12_mp_q - MpW'(9);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[13]) begin
      year_q  <= (m <= MonthW'(2)) ? s12_y_q + YearW'(1) : s12_y_q;
      month_q <= m;
      dom_q   <= dom_full[DomW-1:0];
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign dom_o   = dom_q;

  `ECD_ASSERT(a_date_range, ctrl_i.vld[StgLast] |-> (month_q != '0 && month_q <= MonthW'(12) && dom_q != '0), "date field out of range")

endmodule

// ===== rtl/ecd_time_split.sv =====
`timescale 1ns / 1ps
`include "epoch_ms_to_civil_datetime_core_assert.svh"
module ecd_time_split (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ecd_pkg::ecd_ctrl_t        ctrl_i,
  input  logic [ecd_pkg::MsodW-1:0] msod_i,
  output ecd_pkg::ecd_time_t        tod_o
);
  import ecd_pkg::*;

  localparam int PsW = 49;
  localparam int PhW = 26;
  localparam int PnW = 21;

  // Stage 6: seconds of day
  logic [PsW-1:0]   sec_prod;
  logic [MsodW-1:0] t6_msod_q;
  logic [SodW-1:0]  t6_sod_q;

  assign sec_prod = PsW'(msod_i[MsodW-1:3]) * PsW'(RecipSec);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[6]) begin
      t6_msod_q <= msod_i;
      t6_sod_q  <= sec_prod[31 +: SodW];
    end
  end

  // Stage 7: milliseconds and hour
  logic [MsodW-1:0] pms, dms;
  logic [PhW-1:0]   hour_prod;
  logic [SodW-1:0]  t7_sod_q;
  logic [MsecW-1:0] t7_msec_q;
  logic [HourW-1:0] t7_hour_q;

  assign pms       = MsodW'(t6_sod_q) * MsodW'(MsPerSec);
  assign dms       = t6_msod_q - pms;
  assign hour_prod = PhW'(t6_sod_q[SodW-1:4]) * PhW'(RecipHour);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[7]) begin
      t7_sod_q  <= t6_sod_q;
      t7_msec_q <= dms[MsecW-1:0];
      t7_hour_q <= hour_prod[20 +: HourW];
    end
  end

  // Stage 8: seconds within the hour
  logic [SodW-1:0]    ph, dh;
  logic [MinRemW-1:0] t8_rem_q;
  logic [MsecW-1:0]   t8_msec_q;
  logic [HourW-1:0]   t8_hour_q;

  assign ph = SodW'(t7_hour_q) * SodW'(SecPerHour);
  assign dh = t7_sod_q - ph;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[8]) begin
      t8_rem_q  <= dh[MinRemW-1:0];
      t8_msec_q <= t7_msec_q;
      t8_hour_q <= t7_hour_q;
    end
  end

  // Stage 9: minute
  logic [PnW-1:0]     min_prod;
  logic [MinRemW-1:0] t9_rem_q;
  logic [MsecW-1:0]   t9_msec_q;
  logic [HourW-1:0]   t9_hour_q;
  logic [MinW-1:0]    t9_min_q;

  assign min_prod = PnW'(t8_rem_q[MinRemW-1:2]) * PnW'(RecipMin);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[9]) begin
      t9_rem_q  <= t8_rem_q;
      t9_msec_q <= t8_msec_q;
      t9_hour_q <= t8_hour_q;
      t9_min_q  <= min_prod[14 +: MinW];
    end
  end

  // Stage 10: second
  logic [MinRemW-1:0] pm, dm;
  ecd_time_t          t10_q, t11_q, t12_q, t13_q;

  assign pm = MinRemW'(t9_min_q) * MinRemW'(SecPerMin);
  assign dm = t9_rem_q - pm;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[10]) begin
      t10_q.hour   <= t9_hour_q;
      t10_q.minute <= t9_min_q;
      t10_q.second <= dm[SecW-1:0];
      t10_q.msec   <= t9_msec_q;
    end
  end

  // Stages 11 to 13: align with the date path
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[11]) begin
      t11_q <= t10_q;
    end
    if (ctrl_i.en[12]) begin
      t12_q <= t11_q;
    end
    if (ctrl_i.en[13]) begin
      t13_q <= t12_q;
    end
  end

  assign tod_o = t13_q;

  `ECD_ASSERT(a_time_range, ctrl_i.vld[StgLast] |-> (t13_q.hour <= HourW'(23) && t13_q.minute <= MinW'(59) && t13_q.second <= SecW'(59) && t13_q.msec <= MsecW'(999)), "time field out of range")

endmodule
